@@ hw/rtl/pru_pkg.sv @@
// ---------------------------------------------------------------------------
// pru_pkg: shared types and constants of the pixel replicate upscaler
// widths, codes and the command passed from front end to back end
// ---------------------------------------------------------------------------
package pru_pkg;

   localparam int WIDTH_MAX   = 2048;
   localparam int MAX_SCALE   = 8;

   localparam int COL_W       = $clog2(WIDTH_MAX);
   localparam int WIDTH_W     = 12;
   localparam int SCALE_W     = 4;
   localparam int REPLAY_W    = 3;
   localparam int PAD_W       = 2;
   localparam int PIXEL_W     = 24;

   localparam int FIFO_DEPTH  = 4;
   localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
   localparam int FIFO_LVL_W  = $clog2(FIFO_DEPTH + 1);

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 12;

   // input item kinds
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH = 1'b1;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   // one command: a pixel to be sent out count times
   typedef struct packed {
      logic                 at_end;
      logic [PAD_W-1:0]     pad;
      logic [SCALE_W-1:0]   count;
      pixel_type            pixel;
   } entry_type;

   typedef struct packed {
      logic [SCALE_W-1:0] scale;
      logic [WIDTH_W-1:0] width;
   } config_type;

endpackage

@@ hw/rtl/pru_front.sv @@
// ---------------------------------------------------------------------------
// pru_front: input side of the upscaler
// classifies items, keeps row and replay position, owns the line store
// ---------------------------------------------------------------------------
module pru_front
   import pru_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  config_type            cfg,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [PIXEL_W-1:0]    req_tdata,
   input  logic                  req_tuser,
   input  logic [FIFO_LVL_W-1:0] fifo_level,
   output logic                  push,
   output entry_type             push_entry
);

   logic [COL_W-1:0]    column_ff, column_in;
   logic [REPLAY_W-1:0] replay_ff, replay_in;
   logic                replaying_ff, replaying_in;

   logic                s1_valid_ff;
   logic                s1_tick_ff;
   pixel_type           s1_pixel_ff;
   logic                s1_at_end_ff;
   logic [PAD_W-1:0]    s1_pad_ff;
   logic [SCALE_W-1:0]  s1_count_ff;

   pixel_type           line_store_mem [WIDTH_MAX];
   pixel_type           mem_rd_ff;

   logic [SCALE_W-1:0]  scale_eff;
   logic [WIDTH_W-1:0]  width_eff;
   logic [3:0]          ws_low;
   logic [1:0]          bytes_low;
   logic [PAD_W-1:0]    pad;
   logic                at_end;
   logic                accept;
   logic                take_pixel;
   logic                take_tick;
   logic                take;

   // clamp registers to their useful range
   always_comb begin
      if (cfg.scale == '0) begin
         scale_eff = SCALE_W'(1);
      end else if (cfg.scale > SCALE_W'(MAX_SCALE)) begin
         scale_eff = SCALE_W'(MAX_SCALE);
      end else begin
         scale_eff = cfg.scale;
      end
      if (cfg.width == '0) begin
         width_eff = WIDTH_W'(1);
      end else if (cfg.width > WIDTH_W'(WIDTH_MAX)) begin
         width_eff = WIDTH_W'(WIDTH_MAX);
      end else begin
         width_eff = cfg.width;
      end
   end

   // pad to a 4-byte boundary only depends on the low two bits of w*s*3
   always_comb begin
      ws_low    = {2'b00, width_eff[1:0]} * {2'b00, scale_eff[1:0]};
      bytes_low = 2'(ws_low * 4'd3);
      pad       = PAD_W'(2'd0 - bytes_low);
   end

   assign at_end = (WIDTH_W'(column_ff) + WIDTH_W'(1)) >= width_eff;

   // room for this item plus the one still in the read stage
   assign req_tready = ({1'b0, fifo_level} + {{FIFO_LVL_W{1'b0}}, s1_valid_ff})
                       < (FIFO_LVL_W + 1)'(FIFO_DEPTH);
   assign accept     = req_tvalid && req_tready;
   assign take_pixel = accept && (req_tuser == OP_PIXEL) && !replaying_ff;
   assign take_tick  = accept && (req_tuser == OP_TICK) && replaying_ff;
   assign take       = take_pixel || take_tick;

   // column and replay bookkeeping
   always_comb begin
      column_in    = column_ff;
      replay_in    = replay_ff;
      replaying_in = replaying_ff;
      if (take) begin
         if (at_end) begin
            column_in = '0;
            if (take_pixel) begin
               replay_in    = '0;
               replaying_in = scale_eff > SCALE_W'(1);
            end else if (({1'b0, replay_ff} + SCALE_W'(2)) >= scale_eff) begin
               replay_in    = '0;
               replaying_in = 1'b0;
            end else begin
               replay_in = replay_ff + REPLAY_W'(1);
            end
         end else begin
            column_in = column_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff    <= '0;
         replay_ff    <= '0;
         replaying_ff <= 1'b0;
         s1_valid_ff  <= 1'b0;
      end else begin
         column_ff    <= column_in;
         replay_ff    <= replay_in;
         replaying_ff <= replaying_in;
         s1_valid_ff  <= take;
      end
   end

   // line store, one write or one read per cycle
   always_ff @(posedge clock) begin
      if (take_pixel) begin
         line_store_mem[column_ff] <= pixel_type'(req_tdata);
      end
      if (take_tick) begin
         mem_rd_ff <= line_store_mem[column_ff];
      end
   end

   // read stage payload
   always_ff @(posedge clock) begin
      if (take) begin
         s1_tick_ff   <= take_tick;
         s1_pixel_ff  <= pixel_type'(req_tdata);
         s1_at_end_ff <= at_end;
         s1_pad_ff    <= pad;
         s1_count_ff  <= scale_eff;
      end
   end

   // command towards the queue
   always_comb begin
      push              = s1_valid_ff;
      push_entry.at_end = s1_at_end_ff;
      push_entry.pad    = s1_pad_ff;
      push_entry.count  = s1_count_ff;
      push_entry.pixel  = s1_tick_ff ? mem_rd_ff : s1_pixel_ff;
   end

endmodule

@@ hw/rtl/pru_fifo.sv @@
// ---------------------------------------------------------------------------
// pru_fifo: short command queue
// decouples the input side from the copy engine
// ---------------------------------------------------------------------------
module pru_fifo
   import pru_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  entry_type             push_entry,
   input  logic                  pop,
   output entry_type             head,
   output logic                  not_empty,
   output logic [FIFO_LVL_W-1:0] level
);

   entry_type               slot_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_LVL_W-1:0]   level_ff, level_in;

   // pointer and fill level update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + FIFO_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + FIFO_PTR_W'(1) : rd_ptr_ff;
      level_in  = level_ff;
      if (push && !pop) begin
         level_in = level_ff + FIFO_LVL_W'(1);
      end else if (pop && !push) begin
         level_in = level_ff - FIFO_LVL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head      = slot_ff[rd_ptr_ff];
   assign not_empty = level_ff != '0;
   assign level     = level_ff;

endmodule

@@ hw/rtl/pru_back.sv @@
// ---------------------------------------------------------------------------
// pru_back: copy engine
// sends each queued pixel out count times, marking row end and last copy
// ---------------------------------------------------------------------------
module pru_back
   import pru_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  entry_type             head,
   input  logic                  not_empty,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [PIXEL_W-1:0]    rsp_tdata,   // blue, green, red
   output logic [PAD_W:0]        rsp_tuser,   // row_end, pad_bytes
   output logic                  rsp_tlast
);

   logic                 valid_ff, valid_in;
   entry_type            cur_ff;
   logic [SCALE_W-1:0]   copy_ff, copy_in;
   logic                 final_copy;
   logic                 moving;

   assign final_copy = (copy_ff + SCALE_W'(1)) == cur_ff.count;
   assign moving     = valid_ff && rsp_tready;

   // take the next command once the current one has gone out
   assign pop = not_empty && (!valid_ff || (moving && final_copy));

   always_comb begin
      valid_in = valid_ff;
      copy_in  = copy_ff;
      if (pop) begin
         valid_in = 1'b1;
         copy_in  = '0;
      end else if (moving) begin
         if (final_copy) begin
            valid_in = 1'b0;
         end else begin
            copy_in = copy_ff + SCALE_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         copy_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         copy_ff  <= copy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= head;
      end
   end

   // result fields
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = cur_ff.pixel;
   assign rsp_tlast  = final_copy;
   assign rsp_tuser  = (final_copy && cur_ff.at_end) ? {cur_ff.pad, 1'b1} : '0;

endmodule

@@ hw/rtl/pixel_replicate_upscaler_top.sv @@
// ---------------------------------------------------------------------------
// pixel_replicate_upscaler_top: nearest-neighbour integer upscaler
// 24-bit rgb rows replicated scale times in both directions
// ---------------------------------------------------------------------------
// Each pixel transfer (tuser 0) is stored and sent out scale times; after a
// row the stored row is replayed scale-1 more times, one stored pixel per
// tick transfer (tuser 1). Pixels during a replay and ticks outside one give
// no result. The result port moves one copy per cycle while rsp_tready is
// high, so an item that makes scale copies (1 to 8) holds it until its last
// copy has gone out; the input takes one item per cycle while the four-entry
// command queue has room, so the sustained rate is set by the result port. The
// line store (2048 x 24, one port) needs no clearing after reset.
// ---------------------------------------------------------------------------
module pixel_replicate_upscaler_top
   import pru_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [PIXEL_W-1:0]     req_tdata,   // blue_in, green_in, red_in
   input  logic                   req_tuser,   // op
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [PIXEL_W-1:0]     rsp_tdata,   // blue_out, green_out, red_out
   output logic [PAD_W:0]         rsp_tuser,   // row_end, pad_bytes
   output logic                   rsp_tlast
);

   config_type               cfg_ff;
   logic                     fifo_push;
   entry_type                fifo_push_entry;
   logic                     fifo_pop;
   entry_type                fifo_head;
   logic                     fifo_not_empty;
   logic [FIFO_LVL_W-1:0]    fifo_level;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scale <= SCALE_W'(1);
         cfg_ff.width <= WIDTH_W'(1);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SCALE: cfg_ff.scale <= csr_data[SCALE_W-1:0];
            CSR_WIDTH: cfg_ff.width <= csr_data[WIDTH_W-1:0];
            default: ;
         endcase
      end
   end

   pru_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .fifo_level (fifo_level),
      .push       (fifo_push),
      .push_entry (fifo_push_entry)
   );

   pru_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (fifo_push),
      .push_entry (fifo_push_entry),
      .pop        (fifo_pop),
      .head       (fifo_head),
      .not_empty  (fifo_not_empty),
      .level      (fifo_level)
   );

   pru_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (fifo_head),
      .not_empty  (fifo_not_empty),
      .pop        (fifo_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
